// ===== rtl/core/first_fit_block_allocator_macros.svh =====
// Assertion macros shared by the allocator checker.
// Depends on nothing; each macro takes a clock and an active-low reset.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// No dependencies.
`default_nettype none

package ffba_pkg;

  localparam int POOL_BYTES   = 1048576;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_BLOCKS   = 64;
  localparam int MIN_REST     = 64;

  localparam int SIZE_W = 21;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_NOSTART = 3'd4
  } status_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffba_table.sv =====
// Block table memory: one write and one registered read port.
// Depends on ffba_pkg. Entry 0 reads as the whole pool until first written.
`default_nettype none

module ffba_table import ffba_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;
  logic   w0_q;
  logic   rd_init_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  // Tracks whether entry 0 still holds its reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q      <= 1'b0;
      rd_init_q <= 1'b0;
    end else begin
      if (req_i.we && req_i.waddr == '0) begin
        w0_q <= 1'b1;
      end
      if (req_i.re) begin
        rd_init_q <= (req_i.raddr == '0) && !w0_q;
      end
    end
  end

  always_comb begin
    if (rd_init_q) begin
      rdata_o.size = SIZE_W'(POOL_BYTES - HEADER_BYTES);
      rdata_o.free = 1'b1;
    end else begin
      rdata_o = rd_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with coalescing.
// Depends on ffba_pkg and ffba_table.
//
//  Channel   Dir  tdata (low bit up)              tuser
//  s_axis    in   req_size[20:0], free_addr[41:21] action (0 alloc, 1 free)
//  m_axis    out  status[2:0]                      -
//
// One request is worked at a time. Every table access goes through the single
// table memory, whose read port is registered, so each visited entry takes a
// read state and an evaluate state. An allocate walks entries up to the first
// fit and, when a split occurs, moves every later entry up one place; a free walks
// entries to find the block and then makes a merge pass over every entry in use.
// Reset leaves one free block covering the pool; no clearing pass is needed.
// A finished status waits in S_RESP until the output register is free, and
// s_axis stays stalled meanwhile.
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // req_size[20:0], free_addr[41:21]
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // status[2:0]
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_EV, S_SH_RD, S_SH_EV, S_SPLIT, S_TAKE,
    S_F_RD, S_F_EV, S_M_RD, S_M_EV, S_M_END, S_RESP
  } state_e;

  localparam logic [22:0] HDR23 = 23'(HEADER_BYTES);
  localparam logic [21:0] HDR22 = 22'(HEADER_BYTES);

  state_e            state_q;
  status_e           st_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  i_q;       // walk index
  logic [CNT_W-1:0]  k_q;       // shift index, also merge write index
  logic [IDX_W-1:0]  hit_q;
  logic [21:0]       need_q;
  logic [SIZE_W-1:0] hsize_q;
  logic              split_q;
  logic [21:0]       off_q;
  logic [SIZE_W-1:0] addr_q;
  entry_t            acc_q;
  logic              acc_v_q;
  logic              m_valid_q;
  status_e           m_status_q;

  mem_req_t          mem_req;
  entry_t            rdata;
  entry_t            mdata;
  logic              fits;
  logic              can_split;
  logic              join_run;
  logic [SIZE_W-1:0] req_size;
  logic [SIZE_W-1:0] free_addr;

  assign req_size  = s_axis_tdata[20:0];
  assign free_addr = s_axis_tdata[41:21];

  ffba_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

  // Evaluation of the entry just read.
  assign fits      = rdata.free && ({1'b0, rdata.size} >= need_q);
  assign can_split = ({2'b0, rdata.size} > ({1'b0, need_q} + HDR23 + 23'(MIN_REST)))
                     && (count_q < CNT_W'(MAX_BLOCKS));
  always_comb begin
    mdata      = rdata;
    mdata.free = rdata.free || (i_q[IDX_W-1:0] == hit_q);
  end
  assign join_run = acc_v_q && acc_q.free && mdata.free;

  // Memory port control follows the state.
  always_comb begin
    mem_req = '0;
    unique case (state_q)
      S_A_RD, S_F_RD, S_M_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = i_q[IDX_W-1:0];
      end
      S_SH_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = k_q[IDX_W-1:0];
      end
      S_SH_EV: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(k_q + 1'b1);
        mem_req.wdata = rdata;
      end
      S_SPLIT: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = IDX_W'(hit_q + 1'b1);
        mem_req.wdata.size = SIZE_W'({1'b0, hsize_q} - need_q - HDR22);
        mem_req.wdata.free = 1'b1;
      end
      S_TAKE: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = hit_q;
        mem_req.wdata.size = split_q ? need_q[SIZE_W-1:0] : hsize_q;
        mem_req.wdata.free = 1'b0;
      end
      S_M_EV: begin
        mem_req.we    = acc_v_q && !join_run;
        mem_req.waddr = k_q[IDX_W-1:0];
        mem_req.wdata = acc_q;
      end
      S_M_END: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_q[IDX_W-1:0];
        mem_req.wdata = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      st_q       <= ST_OK;
      count_q    <= CNT_W'(1);
      i_q        <= '0;
      k_q        <= '0;
      hit_q      <= '0;
      split_q    <= 1'b0;
      acc_v_q    <= 1'b0;
      m_valid_q  <= 1'b0;
      m_status_q <= ST_OK;
    end else begin
      // In S_RESP the output register is loaded below instead.
      if (m_valid_q && m_axis_tready && state_q != S_RESP) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            i_q     <= '0;
            addr_q  <= free_addr;
            off_q   <= HDR22;
            split_q <= 1'b0;
            need_q  <= ({1'b0, req_size} + 22'd7) & ~22'd7;
            if (!s_axis_tuser) begin
              if (req_size == '0) begin
                st_q    <= ST_ZERO;
                state_q <= S_RESP;
              end else begin
                state_q <= S_A_RD;
              end
            end else if ({1'b0, free_addr} < HDR22 ||
                         {1'b0, free_addr} >= 22'(POOL_BYTES)) begin
              st_q    <= ST_OUTSIDE;
              state_q <= S_RESP;
            end else begin
              state_q <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          if (i_q >= count_q) begin
            st_q    <= ST_NOMEM;
            state_q <= S_RESP;
          end else begin
            state_q <= S_A_EV;
          end
        end
        S_A_EV: begin
          if (fits) begin
            hit_q   <= i_q[IDX_W-1:0];
            hsize_q <= rdata.size;
            split_q <= can_split;
            k_q     <= count_q - 1'b1;
            if (!can_split) begin
              state_q <= S_TAKE;
            end else if (count_q - 1'b1 > i_q) begin
              state_q <= S_SH_RD;
            end else begin
              state_q <= S_SPLIT;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_A_RD;
          end
        end
        S_SH_RD: begin
          state_q <= S_SH_EV;
        end
        S_SH_EV: begin
          k_q     <= k_q - 1'b1;
          state_q <= (k_q > {1'b0, hit_q} + 1'b1) ? S_SH_RD : S_SPLIT;
        end
        S_SPLIT: begin
          count_q <= count_q + 1'b1;
          state_q <= S_TAKE;
        end
        S_TAKE: begin
          st_q    <= ST_OK;
          state_q <= S_RESP;
        end
        S_F_RD: begin
          if (i_q >= count_q) begin
            st_q    <= ST_NOSTART;
            state_q <= S_RESP;
          end else if (off_q == {1'b0, addr_q}) begin
            hit_q   <= i_q[IDX_W-1:0];
            i_q     <= '0;
            k_q     <= '0;
            acc_v_q <= 1'b0;
            state_q <= S_M_RD;
          end else begin
            state_q <= S_F_EV;
          end
        end
        S_F_EV: begin
          off_q   <= off_q + {1'b0, rdata.size} + HDR22;
          i_q     <= i_q + 1'b1;
          state_q <= S_F_RD;
        end
        S_M_RD: begin
          state_q <= (i_q >= count_q) ? S_M_END : S_M_EV;
        end
        S_M_EV: begin
          // Adjacent free blocks fold into the open block, headers included.
          if (join_run) begin
            acc_q.size <= SIZE_W'({1'b0, acc_q.size} + {1'b0, mdata.size} + HDR22);
          end else begin
            if (acc_v_q) begin
              k_q <= k_q + 1'b1;
            end
            acc_q   <= mdata;
            acc_v_q <= 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_M_RD;
        end
        S_M_END: begin
          count_q <= k_q + 1'b1;
          st_q    <= ST_OK;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_status_q <= st_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_status_q};

endmodule

`default_nettype wire

// ===== rtl/core/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg and first_fit_block_allocator_macros.svh.
`default_nettype none
`include "first_fit_block_allocator_macros.svh"

module ffba_checker import ffba_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  // A result never carries an unknown status code.
  `FFBA_ASSERT_ALWAYS(a_status_range, clk_i, rst_ni, !m_axis_tvalid || m_axis_tdata <= 8'(ST_NOSTART))
  // Once a request is taken the block is not ready in the cycle after.
  `FFBA_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A stalled result holds its status.
  `FFBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
